### hw/rtl/mst_pkg.sv
// Shared constants and control types for the minimum spanning tree block.
// Used by the controller, the datapath and the top level.
package mst_pkg;

   localparam int MaxEdgeCount = 256;
   localparam int MaxNodeCount = 64;
   localparam int EdgeIdxW = $clog2(MaxEdgeCount);
   localparam int EdgeCntW = EdgeIdxW + 1;
   localparam int NodeW = 6;
   localparam int NodeCntW = 7;
   localparam int WeightW = 16;
   localparam int TotalW = 22;
   localparam int EdgeW = 2 * NodeW + WeightW;
   localparam int CntW = EdgeCntW;
   localparam logic [NodeCntW-1:0] NodeCountReset = 7'd64;
   localparam logic [NodeCntW-1:0] MaxNodes = NodeCntW'(MaxNodeCount);

   localparam logic KindEdge = 1'b0;
   localparam logic KindSummary = 1'b1;

   typedef struct packed {
      logic load;
      logic run_init;
      logic cnt_clr;
      logic init_step;
      logic pass_clr;
      logic scan_step;
      logic take_best;
      logic rd_a;
      logic rd_b;
      logic cap_a;
      logic cap_b;
      logic emit_edge;
      logic relabel_step;
      logic emit_sum;
   } cmd_type;

   typedef struct packed {
      logic k_at_n;
      logic k_at_total;
      logic found;
      logic stop;
      logic out_of_range;
      logic same_tree;
   } status_type;

endpackage

### hw/rtl/mst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mst_ctrl.sv
// Sequencing state machine for the minimum spanning tree block.
// Depends on mst_pkg; drives the datapath through cmd_type, watches status_type.
module mst_ctrl
   import mst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       last_edge,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   localparam logic [3:0] StIdle     = 4'd0;
   localparam logic [3:0] StInit     = 4'd1;
   localparam logic [3:0] StPass     = 4'd2;
   localparam logic [3:0] StScan     = 4'd3;
   localparam logic [3:0] StScanEnd  = 4'd4;
   localparam logic [3:0] StCheck    = 4'd5;
   localparam logic [3:0] StRdA      = 4'd6;
   localparam logic [3:0] StRdB      = 4'd7;
   localparam logic [3:0] StCmp      = 4'd8;
   localparam logic [3:0] StRelabel  = 4'd9;
   localparam logic [3:0] StSummary  = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_edge) begin
                  cmd.run_init = 1'b1;
                  cmd.cnt_clr = 1'b1;
                  state_in = StInit;
               end
            end
         end
         StInit: begin
            if (!status.k_at_n) begin
               cmd.init_step = 1'b1;
            end else begin
               state_in = StPass;
            end
         end
         StPass: begin
            cmd.cnt_clr = 1'b1;
            cmd.pass_clr = 1'b1;
            state_in = status.stop ? StSummary : StScan;
         end
         StScan: begin
            if (!status.k_at_total) begin
               cmd.scan_step = 1'b1;
            end else begin
               state_in = StScanEnd;
            end
         end
         StScanEnd: begin
            state_in = StCheck;
         end
         StCheck: begin
            if (!status.found) begin
               state_in = StSummary;
            end else begin
               cmd.take_best = 1'b1;
               state_in = status.out_of_range ? StPass : StRdA;
            end
         end
         StRdA: begin
            cmd.rd_a = 1'b1;
            state_in = StRdB;
         end
         StRdB: begin
            cmd.rd_b = 1'b1;
            cmd.cap_a = 1'b1;
            state_in = StCmp;
         end
         StCmp: begin
            cmd.cap_b = 1'b1;
            if (status.same_tree) begin
               state_in = StPass;
            end else begin
               cmd.emit_edge = 1'b1;
               cmd.cnt_clr = 1'b1;
               state_in = StRelabel;
            end
         end
         StRelabel: begin
            if (!status.k_at_n) begin
               cmd.relabel_step = 1'b1;
            end else begin
               state_in = StPass;
            end
         end
         StSummary: begin
            cmd.emit_sum = 1'b1;
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != StIdle);

`ifndef SYNTHESIS
   a_sum_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sum |=> state_ff == StIdle)
      else $error("summary did not end the run");
   a_cmp_after_reads: assert property (@(posedge clock) disable iff (reset)
      state_ff == StCmp |-> $past(cmd.rd_b) && $past(cmd.rd_a, 2))
      else $error("tree compare without both label reads");
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("edge loaded while busy");
`endif

endmodule

### hw/rtl/mst_dp.sv
// Datapath: edge store, ordered scan, component labels, totals and result register.
// Depends on mst_pkg and mst_ram.
module mst_dp
   import mst_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic [NodeW-1:0]            req_end_a,
   input  logic [NodeW-1:0]            req_end_b,
   input  logic signed [WeightW-1:0]   req_edge_weight,
   input  logic                        csr_wr_en,
   input  logic [NodeCntW-1:0]         csr_wr_data,
   output logic                        rsp_valid,
   output logic                        rsp_kind,
   output logic [NodeW-1:0]            rsp_out_a,
   output logic [NodeW-1:0]            rsp_out_b,
   output logic signed [WeightW-1:0]   rsp_out_weight,
   output logic signed [TotalW-1:0]    rsp_total_weight,
   output logic                        rsp_overflowed,
   output logic                        rsp_last
);

   logic [NodeCntW-1:0] node_count_ff;
   logic [EdgeCntW-1:0] edge_total_ff;
   logic                ovf_ff;
   logic [CntW-1:0]     k_ff;
   logic [NodeCntW-1:0] n_eff;

   // Scan bookkeeping: previous pick and best candidate of this pass.
   logic                      scan_vld_ff;
   logic [EdgeIdxW-1:0]       scan_idx_ff;
   logic                      have_prev_ff;
   logic signed [WeightW-1:0] prev_w_ff;
   logic [EdgeIdxW-1:0]       prev_idx_ff;
   logic                      found_ff;
   logic [NodeW-1:0]          best_a_ff, best_b_ff;
   logic signed [WeightW-1:0] best_w_ff;
   logic [EdgeIdxW-1:0]       best_idx_ff;

   logic [NodeW-1:0]          la_ff, lb_ff;
   logic                      rl_vld_ff;
   logic [NodeW-1:0]          rl_idx_ff;
   logic [NodeCntW-1:0]       chosen_ff;
   logic signed [TotalW-1:0]  total_ff;

   logic                      rsp_valid_ff, rsp_kind_ff, rsp_ovf_ff, rsp_last_ff;
   logic [NodeW-1:0]          rsp_a_ff, rsp_b_ff;
   logic signed [WeightW-1:0] rsp_w_ff;
   logic signed [TotalW-1:0]  rsp_total_ff;

   logic [EdgeW-1:0]          edge_rd;
   logic [NodeW-1:0]          e_a, e_b;
   logic signed [WeightW-1:0] e_w;
   logic                      after_prev, better;
   logic                      store_wr;

   logic                      lbl_wr;
   logic [NodeW-1:0]          lbl_wr_addr, lbl_wr_data, lbl_rd_addr, lbl_rd;
   logic signed [TotalW-1:0]  total_next;

   assign n_eff = (node_count_ff > MaxNodes) ? MaxNodes : node_count_ff;
   assign store_wr = cmd.load && (edge_total_ff < EdgeCntW'(MaxEdgeCount));

   mst_ram #(.WIDTH(EdgeW), .DEPTH(MaxEdgeCount)) u_edge_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (edge_total_ff[EdgeIdxW-1:0]),
      .wr_data ({req_end_a, req_end_b, req_edge_weight}),
      .rd_addr (k_ff[EdgeIdxW-1:0]),
      .rd_data (edge_rd)
   );

   assign e_a = edge_rd[EdgeW-1 -: NodeW];
   assign e_b = edge_rd[WeightW +: NodeW];
   assign e_w = edge_rd[WeightW-1:0];

   // Next in order is the smallest (weight, index) key above the previous pick.
   assign after_prev = !have_prev_ff || (e_w > prev_w_ff) ||
                       ((e_w == prev_w_ff) && (scan_idx_ff > prev_idx_ff));
   assign better = !found_ff || (e_w < best_w_ff);

   // Each node carries a component label; a union relabels one component.
   always_comb begin
      lbl_wr = 1'b0;
      lbl_wr_addr = rl_idx_ff;
      lbl_wr_data = la_ff;
      if (cmd.init_step) begin
         lbl_wr = 1'b1;
         lbl_wr_addr = k_ff[NodeW-1:0];
         lbl_wr_data = k_ff[NodeW-1:0];
      end else if (rl_vld_ff && (lbl_rd == lb_ff)) begin
         lbl_wr = 1'b1;
      end
      if (cmd.rd_a) begin
         lbl_rd_addr = best_a_ff;
      end else if (cmd.rd_b) begin
         lbl_rd_addr = best_b_ff;
      end else begin
         lbl_rd_addr = k_ff[NodeW-1:0];
      end
   end

   mst_ram #(.WIDTH(NodeW), .DEPTH(MaxNodeCount)) u_label_ram (
      .clock   (clock),
      .wr_en   (lbl_wr),
      .wr_addr (lbl_wr_addr),
      .wr_data (lbl_wr_data),
      .rd_addr (lbl_rd_addr),
      .rd_data (lbl_rd)
   );

   assign total_next = total_ff + TotalW'(best_w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NodeCountReset;
         edge_total_ff <= '0;
         ovf_ff <= 1'b0;
         k_ff <= '0;
         scan_vld_ff <= 1'b0;
         rl_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         chosen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            if (store_wr) begin
               edge_total_ff <= edge_total_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.cnt_clr) begin
            k_ff <= '0;
         end else if (cmd.init_step || cmd.scan_step || cmd.relabel_step) begin
            k_ff <= k_ff + 1'b1;
         end
         scan_vld_ff <= cmd.scan_step;
         rl_vld_ff <= cmd.relabel_step;
         if (cmd.run_init) begin
            have_prev_ff <= 1'b0;
            chosen_ff <= '0;
         end else if (cmd.take_best) begin
            have_prev_ff <= 1'b1;
         end
         if (cmd.pass_clr) begin
            found_ff <= 1'b0;
         end else if (scan_vld_ff && after_prev && better) begin
            found_ff <= 1'b1;
         end
         if (cmd.emit_edge) begin
            chosen_ff <= chosen_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.emit_edge || cmd.emit_sum;
         if (cmd.emit_sum) begin
            edge_total_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= k_ff[EdgeIdxW-1:0];
      rl_idx_ff <= k_ff[NodeW-1:0];
      if (scan_vld_ff && after_prev && better && !cmd.pass_clr) begin
         best_a_ff <= e_a;
         best_b_ff <= e_b;
         best_w_ff <= e_w;
         best_idx_ff <= scan_idx_ff;
      end
      if (cmd.take_best) begin
         prev_w_ff <= best_w_ff;
         prev_idx_ff <= best_idx_ff;
      end
      if (cmd.cap_a) begin
         la_ff <= lbl_rd;
      end
      if (cmd.cap_b) begin
         lb_ff <= lbl_rd;
      end
      if (cmd.run_init) begin
         total_ff <= '0;
      end else if (cmd.emit_edge) begin
         total_ff <= total_next;
      end
      rsp_ovf_ff <= ovf_ff;
      if (cmd.emit_edge) begin
         rsp_kind_ff <= KindEdge;
         rsp_a_ff <= best_a_ff;
         rsp_b_ff <= best_b_ff;
         rsp_w_ff <= best_w_ff;
         rsp_total_ff <= total_next;
         rsp_last_ff <= 1'b0;
      end else begin
         rsp_kind_ff <= KindSummary;
         rsp_a_ff <= '0;
         rsp_b_ff <= '0;
         rsp_w_ff <= '0;
         rsp_total_ff <= total_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign status.k_at_n = (k_ff == CntW'(n_eff));
   assign status.k_at_total = (k_ff == edge_total_ff);
   assign status.found = found_ff;
   assign status.stop = (n_eff <= NodeCntW'(1)) || (chosen_ff == n_eff - 1'b1);
   assign status.out_of_range = ({1'b0, best_a_ff} >= n_eff) ||
                                ({1'b0, best_b_ff} >= n_eff);
   assign status.same_tree = (la_ff == lbl_rd);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_out_a = rsp_a_ff;
   assign rsp_out_b = rsp_b_ff;
   assign rsp_out_weight = rsp_w_ff;
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_sum_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> edge_total_ff == '0 && !ovf_ff)
      else $error("store not cleared after summary");
   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_kind_ff |-> ({1'b0, rsp_a_ff} < n_eff) &&
                                       ({1'b0, rsp_b_ff} < n_eff))
      else $error("chosen edge has an endpoint outside the graph");
   a_scan_pipe: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |-> $past(cmd.scan_step))
      else $error("scan compare without a store read");
`endif

endmodule

### hw/rtl/minimum_spanning_tree.sv
// Top level of the minimum spanning tree block.
// Depends on mst_pkg, mst_ctrl, mst_dp and mst_ram.
//
// Edges are taken one per cycle while busy is low and stored in a 256-entry
// edge store. The request with last_edge set starts a run: busy rises, the
// node labels are set up, and then each pass scans the whole store to find
// the next edge in ascending weight order, ties in arrival order. A candidate
// with both endpoints in range has both endpoint labels looked up; a chosen
// edge is reported and followed by a relabel sweep. Each result is shown on
// rsp_valid for one cycle and cannot be stalled; the summary (rsp_last) ends
// the run and drops busy.
module minimum_spanning_tree
   import mst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [NodeW-1:0]          req_end_a,
   input  logic [NodeW-1:0]          req_end_b,
   input  logic signed [WeightW-1:0] req_edge_weight,
   input  logic                      req_last_edge,
   input  logic                      csr_wr_en,
   input  logic [NodeCntW-1:0]       csr_wr_data,
   output logic                      rsp_valid,
   output logic                      rsp_kind,
   output logic [NodeW-1:0]          rsp_out_a,
   output logic [NodeW-1:0]          rsp_out_b,
   output logic signed [WeightW-1:0] rsp_out_weight,
   output logic signed [TotalW-1:0]  rsp_total_weight,
   output logic                      rsp_overflowed,
   output logic                      rsp_last
);

   cmd_type    cmd;
   status_type status;

   mst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_edge (req_last_edge),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   mst_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_end_a        (req_end_a),
      .req_end_b        (req_end_b),
      .req_edge_weight  (req_edge_weight),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_out_a        (rsp_out_a),
      .rsp_out_b        (rsp_out_b),
      .rsp_out_weight   (rsp_out_weight),
      .rsp_total_weight (rsp_total_weight),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last         (rsp_last)
   );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Testbench for minimum_spanning_tree: a queue-fed driver loads graphs and
// node counts, a monitor checks each result against an in-bench Kruskal predictor.
// Depends on mst_pkg and the minimum_spanning_tree RTL.
module testbench;
   import mst_pkg::*;

   typedef enum logic [1:0] {OpEdge, OpConfig, OpDrain} op_type;

   typedef struct {
      op_type                 op;
      logic [NodeW-1:0]       a;
      logic [NodeW-1:0]       b;
      logic signed [WeightW-1:0] w;
      logic                   last;
      logic [NodeCntW-1:0]    nc;
   } pending_type;

   typedef struct {
      logic                      kind;
      logic [NodeW-1:0]          a;
      logic [NodeW-1:0]          b;
      logic signed [WeightW-1:0] w;
      logic signed [TotalW-1:0]  total;
      logic                      ovf;
      logic                      last;
   } tree_result_type;

   logic clock, reset, start, busy;
   logic [NodeW-1:0] req_end_a, req_end_b;
   logic signed [WeightW-1:0] req_edge_weight;
   logic req_last_edge, csr_wr_en;
   logic [NodeCntW-1:0] csr_wr_data;
   logic rsp_valid, rsp_kind, rsp_overflowed, rsp_last;
   logic [NodeW-1:0] rsp_out_a, rsp_out_b;
   logic signed [WeightW-1:0] rsp_out_weight;
   logic signed [TotalW-1:0] rsp_total_weight;

   pending_type     pending_q[$];
   tree_result_type tree_q[$];
   int error_count = 0;
   int cycle_count = 0;
   int settle_count = 0;

   // Predictor state.
   logic [NodeW-1:0]          st_a[MaxEdgeCount];
   logic [NodeW-1:0]          st_b[MaxEdgeCount];
   int                        st_w[MaxEdgeCount];
   int                        st_count;
   logic                      st_ovf;
   int                        node_cfg;
   int                        parent[MaxNodeCount];
   int                        rank_val[MaxNodeCount];

   minimum_spanning_tree u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_end_a(req_end_a), .req_end_b(req_end_b),
      .req_edge_weight(req_edge_weight), .req_last_edge(req_last_edge),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_out_a(rsp_out_a),
      .rsp_out_b(rsp_out_b), .rsp_out_weight(rsp_out_weight),
      .rsp_total_weight(rsp_total_weight), .rsp_overflowed(rsp_overflowed),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic int find_root(input int x);
      int r, guard, nx;
      r = x;
      guard = 0;
      while (parent[r] != r && guard < MaxNodeCount) begin
         r = parent[r];
         guard++;
      end
      while (parent[x] != r && x != r) begin
         nx = parent[x];
         parent[x] = r;
         x = nx;
      end
      return r;
   endfunction

   task automatic predict_tree(input logic [NodeW-1:0] a, input logic [NodeW-1:0] b,
                               input logic signed [WeightW-1:0] w, input logic last);
      int order[MaxEdgeCount];
      int i, j, n, chosen, total, ra, rb, e;
      tree_result_type r;
      if (st_count < MaxEdgeCount) begin
         st_a[st_count] = a;
         st_b[st_count] = b;
         st_w[st_count] = int'(w);
         st_count++;
      end else begin
         st_ovf = 1'b1;
      end
      if (!last) return;
      // Stable insertion sort keeps arrival order among equal weights.
      for (i = 0; i < st_count; i++) begin
         j = i;
         while (j > 0 && st_w[order[j-1]] > st_w[i]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      n = node_cfg > MaxNodeCount ? MaxNodeCount : node_cfg;
      for (i = 0; i < n; i++) begin
         parent[i] = i;
         rank_val[i] = 0;
      end
      chosen = 0;
      total = 0;
      for (i = 0; i < st_count && n > 1 && chosen < n - 1; i++) begin
         e = order[i];
         if (st_a[e] >= n || st_b[e] >= n) continue;
         ra = find_root(st_a[e]);
         rb = find_root(st_b[e]);
         if (ra == rb) continue;
         if (rank_val[ra] > rank_val[rb]) parent[rb] = ra;
         else if (rank_val[ra] < rank_val[rb]) parent[ra] = rb;
         else begin
            parent[rb] = ra;
            rank_val[ra] = (rank_val[ra] + 1) & 7;
         end
         total += st_w[e];
         chosen++;
         r.kind = KindEdge;
         r.a = st_a[e];
         r.b = st_b[e];
         r.w = st_w[e];
         r.total = total;
         r.ovf = st_ovf;
         r.last = 1'b0;
         tree_q.push_back(r);
      end
      r.kind = KindSummary;
      r.a = '0;
      r.b = '0;
      r.w = '0;
      r.total = total;
      r.ovf = st_ovf;
      r.last = 1'b1;
      tree_q.push_back(r);
      st_count = 0;
      st_ovf = 1'b0;
   endtask

   // Driver: start is held while busy; a config write or drain waits for quiet.
   always @(posedge clock) begin
      pending_type p;
      logic take, quiet_run;
      if (reset) begin
         start <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         cycle_count++;
         if (tree_q.size() == 0 && !busy && !start) settle_count++;
         else settle_count = 0;
         if (csr_wr_en) node_cfg = int'(csr_wr_data);
         if (start && !busy)
            predict_tree(req_end_a, req_end_b, req_edge_weight, req_last_edge);
         take = !(start && busy);
         quiet_run = cycle_count >= 3000 && cycle_count < 9000;
         if (take) begin
            start <= 1'b0;
            csr_wr_en <= 1'b0;
            if (pending_q.size() > 0) begin
               p = pending_q[0];
               case (p.op)
                  OpConfig: begin
                     if (settle_count >= 8 && !csr_wr_en) begin
                        csr_wr_en <= 1'b1;
                        csr_wr_data <= p.nc;
                        void'(pending_q.pop_front());
                     end
                  end
                  OpDrain: begin
                     if (settle_count >= 2) void'(pending_q.pop_front());
                  end
                  default: begin
                     if (quiet_run || $urandom_range(99) >= 31) begin
                        start <= 1'b1;
                        req_end_a <= p.a;
                        req_end_b <= p.b;
                        req_edge_weight <= p.w;
                        req_last_edge <= p.last;
                        void'(pending_q.pop_front());
                     end
                  end
               endcase
            end
         end
      end
   end

   // Monitor: results cannot be stalled, so each strobe is checked on the spot.
   always @(posedge clock) begin
      tree_result_type x;
      if (!reset && rsp_valid) begin
         if (tree_q.size() == 0) begin
            $display("unexpected result at cycle %0d", cycle_count);
            error_count++;
         end else begin
            x = tree_q.pop_front();
            if (rsp_kind !== x.kind) report("kind", rsp_kind, x.kind);
            if (rsp_out_a !== x.a) report("out_a", rsp_out_a, x.a);
            if (rsp_out_b !== x.b) report("out_b", rsp_out_b, x.b);
            if (rsp_out_weight !== x.w) report("out_weight", rsp_out_weight, x.w);
            if (rsp_total_weight !== x.total)
               report("total_weight", rsp_total_weight, x.total);
            if (rsp_overflowed !== x.ovf) report("overflowed", rsp_overflowed, x.ovf);
            if (rsp_last !== x.last) report("last", rsp_last, x.last);
         end
      end
   end

   task automatic add_edge(input int a, input int b, input int w, input logic last);
      pending_type p;
      p.op = OpEdge;
      p.a = a;
      p.b = b;
      p.w = w;
      p.last = last;
      p.nc = '0;
      pending_q.push_back(p);
   endtask

   task automatic add_ctl(input op_type op, input int nc);
      pending_type p;
      p.op = op;
      p.a = '0;
      p.b = '0;
      p.w = '0;
      p.last = 1'b0;
      p.nc = nc;
      pending_q.push_back(p);
   endtask

   task automatic add_graph(input int nc, input int edges);
      int i, span, w_lo, w_hi;
      add_ctl(OpConfig, nc);
      span = (nc > MaxNodeCount) ? MaxNodeCount : (nc < 1 ? 1 : nc);
      // Narrow weight ranges force ties now and then.
      w_hi = ($urandom_range(3) == 0) ? 3 : 32767;
      for (i = 0; i < edges; i++) begin
         if ($urandom_range(9) == 0)
            add_edge($urandom_range(63), $urandom_range(63),
                     $urandom_range(65535), i == edges - 1);
         else
            add_edge($urandom_range(span - 1), $urandom_range(span - 1),
                     int'($urandom_range(2 * w_hi + 1)) - w_hi - 1, i == edges - 1);
      end
   endtask

   initial begin
      int k;
      reset = 1'b1;
      start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_end_a = '0;
      req_end_b = '0;
      req_edge_weight = '0;
      req_last_edge = 1'b0;
      st_count = 0;
      st_ovf = 1'b0;
      node_cfg = int'(NodeCountReset);

      // Directed: extreme weights, ties, a self loop, the extreme endpoints.
      add_edge(0, 63, 32767, 0);
      add_edge(63, 0, -32768, 0);
      add_edge(5, 5, -32768, 0);
      add_edge(1, 2, 7, 0);
      add_edge(2, 1, 7, 0);
      add_edge(0, 1, 7, 1);
      // Few nodes: endpoints beyond the count are skipped.
      add_ctl(OpConfig, 4);
      add_edge(0, 4, -5, 0);
      add_edge(63, 1, -9, 0);
      add_edge(0, 1, 3, 0);
      add_edge(1, 2, 3, 0);
      add_edge(2, 3, 1, 0);
      add_edge(3, 0, 0, 1);
      // Tiny graphs with zero and one node.
      add_ctl(OpConfig, 0);
      add_edge(0, 1, 100, 1);
      add_ctl(OpConfig, 1);
      add_edge(0, 0, -1, 0);
      add_edge(0, 1, 2, 1);
      // Node count above the maximum, then a two-node graph.
      add_ctl(OpConfig, 127);
      add_edge(62, 63, -32768, 0);
      add_edge(42, 21, 32767, 1);
      add_ctl(OpConfig, 2);
      add_edge(1, 0, 1, 1);
      add_ctl(OpDrain, 0);

      // Random graphs, then one that overflows the store and two more after a drain.
      for (k = 0; k < 14; k++)
         add_graph(($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(12, 2),
                   $urandom_range(9, 1));
      add_graph(64, MaxEdgeCount + 3);
      add_ctl(OpDrain, 0);
      add_graph(64, 8);
      add_graph(127, 6);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !start);
      wait (tree_q.size() == 0 && !busy);
      repeat (20) @(posedge clock);
      if (error_count == 0 && tree_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
